[hw/rtl/swrm_pkg.sv]
// ----------------------------------------------------------------------------
// Stack with running maximum: shared package
// Depth, widths, operation and status codes, and the command struct that
// the controller hands to the datapath.
// ----------------------------------------------------------------------------
package swrm_pkg;

  localparam int DEPTH   = 16;
  localparam int DATA_W  = 32;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } swrm_cmd_t;

endpackage

[hw/rtl/swrm_if.sv]
// ----------------------------------------------------------------------------
// Stack with running maximum: channel interfaces
// Request channel carrying one stack operation, and response channel
// carrying its result.
// ----------------------------------------------------------------------------
interface swrm_req_if;
  logic                   valid;
  logic                   ready;
  swrm_pkg::opcode_t      opcode;
  logic signed [31:0]     push_value;

  modport source (output valid, output opcode, output push_value, input ready);
  modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

interface swrm_rsp_if;
  logic                   valid;
  logic                   ready;
  swrm_pkg::status_t      status;
  logic signed [31:0]     popped_value;
  logic signed [31:0]     current_max;
  logic                   max_valid;

  modport source (output valid, output status, output popped_value,
                  output current_max, output max_valid, input ready);
  modport sink   (input valid, input status, input popped_value,
                  input current_max, input max_valid, output ready);
endinterface

[hw/rtl/stack_with_running_max_unit.sv]
// ----------------------------------------------------------------------------
// Stack with running maximum: top level
// Bounded stack of signed 32-bit values that reports its current maximum.
//
// Each request on req carries an opcode (push or pop) and a push value. Each
// request gives exactly one response on rsp: a status (ok, full or empty),
// the popped value, and the maximum held afterwards with its valid flag.
// A request is taken in the idle state while the tops of the value store and
// of the maxima store are read from their memories; the execute state then
// decides and writes back. No new request is taken until that one commits.
// The response is loaded into its output register when the request commits,
// and stays until the receiver takes it.
// A finished response may wait while the next request is accepted; if the
// receiver still stalls, that request holds in the execute state until the
// response register frees. Reset empties both stacks at once; the store
// contents are left as they are and never used before being written.
// ----------------------------------------------------------------------------
module stack_with_running_max_unit (
  input  logic       clk,
  input  logic       rst,
  swrm_req_if.sink   req,
  swrm_rsp_if.source rsp
);
  import swrm_pkg::*;

  swrm_cmd_t cmd;

  swrm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  swrm_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .opcode       (req.opcode),
    .push_value   (req.push_value),
    .status       (rsp.status),
    .popped_value (rsp.popped_value),
    .current_max  (rsp.current_max),
    .max_valid    (rsp.max_valid)
  );

endmodule

[hw/rtl/swrm_ctrl.sv]
// ----------------------------------------------------------------------------
// Stack with running maximum: controller
// Two-state sequencer that takes a request, lets the stack tops be read,
// and commits the operation once the response register is free.
// ----------------------------------------------------------------------------
module swrm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output swrm_pkg::swrm_cmd_t cmd
);
  import swrm_pkg::*;

  state_t state;
  state_t state_next;
  logic   rsp_valid_next;
  logic   slot_free;

  assign slot_free = !rsp_valid || rsp_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
      end
      ST_EXEC: begin
        cmd.commit = slot_free;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  assign rsp_valid_next = cmd.commit || (rsp_valid && !rsp_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

[hw/rtl/swrm_datapath.sv]
// ----------------------------------------------------------------------------
// Stack with running maximum: datapath
// Value and maxima stores with registered reads of their tops, the two
// counts, the operation decode and the response register.
// ----------------------------------------------------------------------------
module swrm_datapath (
  input  logic                     clk,
  input  logic                     rst,
  input  swrm_pkg::swrm_cmd_t      cmd,
  input  swrm_pkg::opcode_t        opcode,
  input  logic signed [31:0]       push_value,
  output swrm_pkg::status_t        status,
  output logic signed [31:0]       popped_value,
  output logic signed [31:0]       current_max,
  output logic                     max_valid
);
  import swrm_pkg::*;

  logic signed [DATA_W-1:0] value_mem [DEPTH];
  logic signed [DATA_W-1:0] max_mem [DEPTH];

  logic [CNT_W-1:0]         value_count;
  logic [CNT_W-1:0]         max_count;
  logic [CNT_W-1:0]         value_count_next;
  logic [CNT_W-1:0]         max_count_next;
  logic [CNT_W-1:0]         value_top_idx;
  logic [CNT_W-1:0]         max_top_idx;
  logic [CNT_W-1:0]         max_below_idx;

  opcode_t                  op_q;
  logic signed [DATA_W-1:0] val_q;
  logic signed [DATA_W-1:0] rd_value;
  logic signed [DATA_W-1:0] rd_max_top;
  logic signed [DATA_W-1:0] rd_max_below;

  logic                     full;
  logic                     empty;
  logic                     push_ok;
  logic                     max_push;
  logic                     max_pop;
  status_t                  status_next;
  logic signed [DATA_W-1:0] popped_next;
  logic signed [DATA_W-1:0] max_next;
  logic                     max_valid_next;

  assign value_top_idx = value_count - CNT_W'(1);
  assign max_top_idx   = max_count - CNT_W'(1);
  assign max_below_idx = max_count - CNT_W'(2);

  assign full  = (value_count == CNT_W'(DEPTH));
  assign empty = (value_count == '0);

  always_comb begin
    push_ok          = 1'b0;
    max_push         = 1'b0;
    max_pop          = 1'b0;
    status_next      = STATUS_OK;
    popped_next      = '0;
    max_next         = rd_max_top;
    value_count_next = value_count;
    max_count_next   = max_count;
    case (op_q)
      OP_PUSH: begin
        if (full) begin
          status_next = STATUS_FULL;
        end else begin
          push_ok          = 1'b1;
          value_count_next = value_count + CNT_W'(1);
          max_push         = (max_count == '0 || val_q >= rd_max_top) &&
                             (max_count != CNT_W'(DEPTH));
          if (max_push) begin
            max_count_next = max_count + CNT_W'(1);
            max_next       = val_q;
          end
        end
      end
      OP_POP: begin
        if (empty) begin
          status_next = STATUS_EMPTY;
        end else begin
          popped_next      = rd_value;
          value_count_next = value_count - CNT_W'(1);
          max_pop          = (max_count != '0) && (rd_value == rd_max_top);
          if (max_pop) begin
            max_count_next = max_count - CNT_W'(1);
            max_next       = rd_max_below;
          end
        end
      end
      default: begin
        status_next = STATUS_OK;
      end
    endcase
    max_valid_next = (value_count_next != '0) && (max_count_next != '0);
    if (!max_valid_next) max_next = '0;
  end

  always_ff @(posedge clk) begin
    rd_value     <= value_mem[value_top_idx[ADDR_W-1:0]];
    rd_max_top   <= max_mem[max_top_idx[ADDR_W-1:0]];
    rd_max_below <= max_mem[max_below_idx[ADDR_W-1:0]];
    if (cmd.commit && push_ok) value_mem[value_count[ADDR_W-1:0]] <= val_q;
    if (cmd.commit && max_push) max_mem[max_count[ADDR_W-1:0]] <= val_q;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= opcode;
      val_q <= push_value;
    end
    if (cmd.commit) begin
      status       <= status_next;
      popped_value <= popped_next;
      current_max  <= max_next;
      max_valid    <= max_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value_count <= '0;
      max_count   <= '0;
    end else if (cmd.commit) begin
      value_count <= value_count_next;
      max_count   <= max_count_next;
    end
  end

endmodule

[hw/rtl/swrm_checker.sv]
// ----------------------------------------------------------------------------
// Stack with running maximum: port checker
// Concurrent checks on the top-level channels, bound to the top level.
// ----------------------------------------------------------------------------
module swrm_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic               req_ready,
  input  logic               rsp_valid,
  input  logic               rsp_ready,
  input  swrm_pkg::status_t  status,
  input  logic signed [31:0] popped_value,
  input  logic signed [31:0] current_max,
  input  logic               max_valid
);
  import swrm_pkg::*;

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) &&
      $stable(popped_value) && $stable(current_max) && $stable(max_valid))
    else $error("stalled response changed");

  assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid straight after reset");

  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while one is in progress");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !max_valid |-> current_max == 0)
    else $error("maximum reported for an empty stack");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != STATUS_OK |-> popped_value == 0)
    else $error("refused request reported a popped value");

endmodule

bind stack_with_running_max_unit swrm_checker u_swrm_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .status       (rsp.status),
  .popped_value (rsp.popped_value),
  .current_max  (rsp.current_max),
  .max_valid    (rsp.max_valid)
);

[tb/tb_stack_with_running_max_unit.sv]
// ----------------------------------------------------------------------------
// Stack with running maximum: testbench
// Drives push and pop requests into the unit and checks every response
// against a behavioural stack kept alongside it. Directed tests cover the
// extreme values, repeated maxima, a full stack and an empty stack. A phase
// that holds the response channel off long enough to stall requests comes
// next, then random phases with varying push bias and idling on both channels.
// ----------------------------------------------------------------------------
module tb_stack_with_running_max_unit;
  import swrm_pkg::*;

  typedef struct {
    status_t            status;
    logic signed [31:0] popped_value;
    logic signed [31:0] current_max;
    logic               max_valid;
  } stack_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  swrm_req_if req_ch ();
  swrm_rsp_if rsp_ch ();

  stack_with_running_max_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  logic signed [31:0] value_stack [DEPTH];
  logic signed [31:0] maxima_stack [DEPTH];
  int                 value_depth = 0;
  int                 maxima_depth = 0;

  stack_report_t      predicted_reports [$];
  int                 error_count = 0;
  int                 req_gap_pct = 0;
  int                 rsp_stall_pct = 0;
  int                 hold_off_cycles = 0;

  always #4 clk = ~clk;

  function automatic stack_report_t apply_stack_op(opcode_t op, logic signed [31:0] value);
    stack_report_t r;
    r.status       = STATUS_OK;
    r.popped_value = '0;
    r.current_max  = '0;
    r.max_valid    = 1'b0;
    if (op == OP_PUSH) begin
      if (value_depth == DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        if (maxima_depth == 0 || value >= maxima_stack[maxima_depth - 1]) begin
          maxima_stack[maxima_depth] = value;
          maxima_depth++;
        end
        value_stack[value_depth] = value;
        value_depth++;
      end
    end else begin
      if (value_depth == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        r.popped_value = value_stack[value_depth - 1];
        value_depth--;
        if (maxima_depth > 0 && r.popped_value == maxima_stack[maxima_depth - 1]) begin
          maxima_depth--;
        end
      end
    end
    if (value_depth > 0 && maxima_depth > 0) begin
      r.current_max = maxima_stack[maxima_depth - 1];
      r.max_valid   = 1'b1;
    end
    return r;
  endfunction

  // When a gap is drawn, roughly one in ten is long and the rest are short.
  function automatic int draw_gap(int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic signed [31:0] draw_value();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2, 3: return $signed($urandom_range(0, 8)) - 4;
      4: return (maxima_depth > 0) ? maxima_stack[maxima_depth - 1] : $signed($urandom);
      default: return $signed($urandom);
    endcase
  endfunction

  function automatic opcode_t draw_op(int push_pct);
    return ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
  endfunction

  task automatic issue_op(input opcode_t op, input logic signed [31:0] value);
    int gap;
    gap = draw_gap(req_gap_pct);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.opcode     <= op;
    req_ch.push_value <= value;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted_reports.push_back(apply_stack_op(op, value));
  endtask

  initial begin : receiver
    int stall_left;
    stall_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_off_cycles--;
      end else if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        stall_left = draw_gap(rsp_stall_pct);
        rsp_ch.ready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  always @(posedge clk) begin
    stack_report_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (predicted_reports.size() == 0) begin
        $error("response arrived with no request outstanding");
        error_count++;
      end else begin
        want = predicted_reports.pop_front();
        if (rsp_ch.status !== want.status) begin
          $error("field status expected %0d actual %0d", want.status, rsp_ch.status);
          error_count++;
        end
        if (rsp_ch.popped_value !== want.popped_value) begin
          $error("field popped_value expected %0d actual %0d",
                 want.popped_value, rsp_ch.popped_value);
          error_count++;
        end
        if (rsp_ch.current_max !== want.current_max) begin
          $error("field current_max expected %0d actual %0d",
                 want.current_max, rsp_ch.current_max);
          error_count++;
        end
        if (rsp_ch.max_valid !== want.max_valid) begin
          $error("field max_valid expected %0d actual %0d", want.max_valid, rsp_ch.max_valid);
          error_count++;
        end
      end
    end
  end

  task automatic test_extremes_and_repeated_max;
    req_gap_pct   = 30;
    rsp_stall_pct = 30;
    issue_op(OP_POP, 32'sh1234_5678);
    issue_op(OP_PUSH, 32'sh8000_0000);
    issue_op(OP_PUSH, 32'sh7fff_ffff);
    issue_op(OP_PUSH, 32'sh0000_0000);
    issue_op(OP_PUSH, -32'sd1);
    issue_op(OP_PUSH, 32'sh7fff_ffff);
    issue_op(OP_POP, 32'shffff_ffff);
    issue_op(OP_POP, 32'sh0);
    issue_op(OP_POP, 32'sh0);
    issue_op(OP_POP, 32'sh0);
    issue_op(OP_POP, 32'sh0);
    issue_op(OP_POP, 32'sh0);
    issue_op(OP_PUSH, 32'shaaaa_aaaa);
    issue_op(OP_PUSH, 32'sh5555_5555);
    issue_op(OP_PUSH, 32'sh5555_5555);
    issue_op(OP_POP, 32'shaaaa_aaaa);
    issue_op(OP_POP, 32'sh5555_5555);
    issue_op(OP_POP, 32'sh0);
  endtask

  task automatic test_full_and_empty;
    req_gap_pct   = 0;
    rsp_stall_pct = 0;
    for (int i = 0; i < DEPTH; i++) begin
      issue_op(OP_PUSH, $signed(32'd1000 - 32'(i * 37)));
    end
    issue_op(OP_PUSH, 32'sh7fff_ffff);
    issue_op(OP_PUSH, 32'sh8000_0000);
    for (int i = 0; i < DEPTH; i++) begin
      issue_op(OP_POP, $signed($urandom));
    end
    issue_op(OP_POP, 32'sh0);
  endtask

  task automatic test_response_backpressure;
    req_gap_pct     = 0;
    rsp_stall_pct   = 0;
    hold_off_cycles = 150;
    for (int i = 0; i < 40; i++) begin
      issue_op(draw_op(70), draw_value());
    end
  endtask

  task automatic test_random_sequences;
    int sent;
    int phase_len;
    int push_pct;
    sent = 0;
    while (sent < 1050) begin
      phase_len = $urandom_range(20, 60);
      case ($urandom_range(0, 3))
        0: push_pct = 25;
        1: push_pct = 50;
        2: push_pct = 75;
        default: push_pct = 90;
      endcase
      case ($urandom_range(0, 3))
        0: begin
          req_gap_pct   = 0;
          rsp_stall_pct = 0;
        end
        1: begin
          req_gap_pct   = 20;
          rsp_stall_pct = 20;
        end
        2: begin
          req_gap_pct   = 50;
          rsp_stall_pct = 10;
        end
        default: begin
          req_gap_pct   = 10;
          rsp_stall_pct = 50;
        end
      endcase
      repeat (phase_len) begin
        issue_op(draw_op(push_pct), draw_value());
        sent++;
      end
    end
  endtask

  initial begin
    int drain_cycles;
    req_ch.valid      <= 1'b0;
    req_ch.opcode     <= OP_PUSH;
    req_ch.push_value <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extremes_and_repeated_max();
    test_full_and_empty();
    test_response_backpressure();
    test_random_sequences();

    req_ch.valid <= 1'b0;
    rsp_stall_pct = 0;
    drain_cycles = 0;
    while (predicted_reports.size() > 0 && drain_cycles < 5000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (8) @(posedge clk);
    if (predicted_reports.size() > 0) begin
      $error("%0d responses never arrived", predicted_reports.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(8 * 600000);
    $display("status: fail");
    $finish;
  end

endmodule

[stack_with_running_max_unit.f]
hw/rtl/swrm_pkg.sv
hw/rtl/swrm_if.sv
hw/rtl/swrm_ctrl.sv
hw/rtl/swrm_datapath.sv
hw/rtl/stack_with_running_max_unit.sv
hw/rtl/swrm_checker.sv
tb/tb_stack_with_running_max_unit.sv
